@@ design/crc32_checked_frame_receiver_macros.svh @@
// Assertion macros used by the receiver control module.
`ifndef CRC32_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define CRC32_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CRCFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CRCFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/crcfr_pkg.sv @@
`default_nettype none
package crcfr_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int STORE_DEPTH     = 64;
  localparam int ADDR_W          = 6;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 8;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [7:0]        MAGIC_RST   = 8'd170;
  localparam logic [7:0]        VERSION_RST = 8'd1;
  localparam logic [ADDR_W-1:0] VER_POS_RST = 6'd1;
  localparam logic [ADDR_W-1:0] SEQ_POS_RST = 6'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_VERSION = 2'd1,
    CFG_VER_POS = 2'd2,
    CFG_SEQ_POS = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_VER = 2'd1,
    ST_BAD_CRC = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_VER    = 2'd0,
    RD_SEQ_LO = 2'd1,
    RD_SEQ_HI = 2'd2,
    RD_IDX    = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              crc_start;
    logic              crc_upd;
    logic              rxcrc_shift;
    rd_sel_t           rd_sel;
    logic [ADDR_W-1:0] rd_idx;
    logic              seq_lo_ld;
    logic              seq_commit;
    logic              out_ld;
    logic              out_err;
    status_t           out_status;
    logic              out_last;
    logic [ADDR_W-1:0] out_pos;
  } dp_cmd_t;

  typedef struct packed {
    logic magic_hit;
    logic ver_ok;
    logic crc_ok;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ design/crcfr_dp.sv @@
`default_nettype none
module crcfr_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [crcfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [7:0]                       rx_byte,
  input  wire crcfr_pkg::dp_cmd_t               cmd,
  output crcfr_pkg::dp_stat_t                   stat,
  output logic [7:0]                            data_byte,
  output logic [crcfr_pkg::ADDR_W-1:0]          byte_position,
  output logic                                  last,
  output crcfr_pkg::status_t                    status,
  output logic [15:0]                           sequence_res,
  output logic                                  sequence_gap
);

  localparam int AW = crcfr_pkg::ADDR_W;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ crcfr_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [7:0]    magic_r;
  logic [7:0]    version_r;
  logic [AW-1:0] ver_pos_r;
  logic [AW-1:0] seq_pos_r;

  logic [7:0]    store_mem [crcfr_pkg::STORE_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data_r;

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic [31:0] rxcrc_r;
  logic [7:0]  seq_lo_r;
  logic [15:0] seq_word;
  logic [15:0] seq_r;
  logic        gap_r;
  logic        gap_nxt;
  logic [15:0] prev_seq_r;
  logic        first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= crcfr_pkg::MAGIC_RST;
      version_r <= crcfr_pkg::VERSION_RST;
      ver_pos_r <= crcfr_pkg::VER_POS_RST;
      seq_pos_r <= crcfr_pkg::SEQ_POS_RST;
    end else if (cfg_we) begin
      unique case (crcfr_pkg::cfg_idx_t'(cfg_addr))
        crcfr_pkg::CFG_MAGIC:   magic_r   <= cfg_wdata;
        crcfr_pkg::CFG_VERSION: version_r <= cfg_wdata;
        crcfr_pkg::CFG_VER_POS: ver_pos_r <= cfg_wdata[AW-1:0];
        crcfr_pkg::CFG_SEQ_POS: seq_pos_r <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      crcfr_pkg::RD_VER:    rd_addr = ver_pos_r;
      crcfr_pkg::RD_SEQ_LO: rd_addr = seq_pos_r;
      crcfr_pkg::RD_SEQ_HI: rd_addr = seq_pos_r + AW'(1);
      crcfr_pkg::RD_IDX:    rd_addr = cmd.rd_idx;
      default:              rd_addr = cmd.rd_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store_mem[cmd.wr_addr] <= rx_byte;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  assign crc_nxt = crc_byte(cmd.crc_start ? crcfr_pkg::CRC_INIT : crc_r, rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= crcfr_pkg::CRC_INIT;
    end else if (cmd.crc_upd) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rxcrc_shift) begin
      rxcrc_r <= {rx_byte, rxcrc_r[31:8]};
    end
    if (cmd.seq_lo_ld) begin
      seq_lo_r <= rd_data_r;
    end
  end

  assign seq_word = {rd_data_r, seq_lo_r};
  assign gap_nxt  = !first_r && (seq_word != (prev_seq_r + 16'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_seq_r <= 16'd0;
      first_r    <= 1'b1;
    end else if (cmd.seq_commit) begin
      prev_seq_r <= seq_word;
      first_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seq_commit) begin
      seq_r <= seq_word;
      gap_r <= gap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      if (cmd.out_err) begin
        data_byte     <= 8'd0;
        byte_position <= '0;
        last          <= 1'b1;
        status        <= cmd.out_status;
        sequence_res  <= 16'd0;
        sequence_gap  <= 1'b0;
      end else begin
        data_byte     <= rd_data_r;
        byte_position <= cmd.out_pos;
        last          <= cmd.out_last;
        status        <= crcfr_pkg::ST_OK;
        sequence_res  <= seq_r;
        sequence_gap  <= gap_r;
      end
    end
  end

  assign stat.magic_hit = (rx_byte == magic_r);
  assign stat.ver_ok    = (rd_data_r == version_r);
  assign stat.crc_ok    = (~crc_r == rxcrc_r);

endmodule
`default_nettype wire

@@ design/crcfr_ctrl.sv @@
`default_nettype none
`include "crc32_checked_frame_receiver_macros.svh"
module crcfr_ctrl #(
  parameter int FRAME_BYTES = crcfr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire crcfr_pkg::dp_stat_t stat,
  output crcfr_pkg::dp_cmd_t       cmd
);

  localparam int FILL_W = $clog2(FRAME_BYTES);
  localparam int AW     = crcfr_pkg::ADDR_W;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_BYTES - 1);
  localparam logic [FILL_W-1:0] CRC_END   = FILL_W'(FRAME_BYTES - 4);
  localparam logic [FILL_W-1:0] IDX_LAST  = FILL_W'(FRAME_BYTES - 5);

  typedef enum logic [5:0] {
    S_RX   = 6'b000001,
    S_RDV  = 6'b000010,
    S_CHKV = 6'b000100,
    S_SEQL = 6'b001000,
    S_SEQH = 6'b010000,
    S_STRM = 6'b100000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] idx_r;
  logic [FILL_W-1:0] idx_nxt;
  logic              out_valid_r;
  logic              slot_free;
  logic              in_acc;

  assign in_tready  = (state_r == S_RX);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    cmd.wr_en      = 1'b0;
    cmd.wr_addr    = AW'(fill_r);
    cmd.crc_start  = 1'b0;
    cmd.crc_upd    = 1'b0;
    cmd.rxcrc_shift = 1'b0;
    cmd.rd_sel     = crcfr_pkg::RD_IDX;
    cmd.rd_idx     = AW'(idx_r);
    cmd.seq_lo_ld  = 1'b0;
    cmd.seq_commit = 1'b0;
    cmd.out_ld     = 1'b0;
    cmd.out_err    = 1'b0;
    cmd.out_status = crcfr_pkg::ST_OK;
    cmd.out_last   = (idx_r == IDX_LAST);
    cmd.out_pos    = AW'(idx_r);
    unique case (state_r)
      S_RX: begin
        if (in_acc && (fill_r != '0 || stat.magic_hit)) begin
          cmd.wr_en       = 1'b1;
          cmd.crc_start   = (fill_r == '0);
          cmd.crc_upd     = (fill_r < CRC_END);
          cmd.rxcrc_shift = (fill_r >= CRC_END);
          if (fill_r == FILL_LAST) begin
            fill_nxt  = '0;
            state_nxt = S_RDV;
          end else begin
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
      end
      S_RDV: begin
        cmd.rd_sel = crcfr_pkg::RD_VER;
        state_nxt  = S_CHKV;
      end
      S_CHKV: begin
        cmd.rd_sel = crcfr_pkg::RD_VER;
        if (!stat.ver_ok || !stat.crc_ok) begin
          if (slot_free) begin
            cmd.out_ld     = 1'b1;
            cmd.out_err    = 1'b1;
            cmd.out_last   = 1'b1;
            cmd.out_status = stat.ver_ok ? crcfr_pkg::ST_BAD_CRC : crcfr_pkg::ST_BAD_VER;
            state_nxt      = S_RX;
          end
        end else begin
          cmd.rd_sel = crcfr_pkg::RD_SEQ_LO;
          state_nxt  = S_SEQL;
        end
      end
      S_SEQL: begin
        cmd.seq_lo_ld = 1'b1;
        cmd.rd_sel    = crcfr_pkg::RD_SEQ_HI;
        state_nxt     = S_SEQH;
      end
      S_SEQH: begin
        cmd.seq_commit = 1'b1;
        cmd.rd_idx     = '0;
        idx_nxt        = '0;
        state_nxt      = S_STRM;
      end
      S_STRM: begin
        if (slot_free) begin
          cmd.out_ld = 1'b1;
          if (idx_r == IDX_LAST) begin
            state_nxt = S_RX;
          end else begin
            idx_nxt    = idx_r + FILL_W'(1);
            cmd.rd_idx = AW'(idx_nxt);
          end
        end
      end
      default: begin
        state_nxt = S_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RX;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `CRCFR_ASSERT_IMP(a_load_into_free_slot, cmd.out_ld, !out_valid_r || out_tready,
                    "result loaded over an item not yet taken")
  `CRCFR_ASSERT_NXT(a_frame_end_starts_check, in_acc && fill_r == FILL_LAST, state_r == S_RDV,
                    "completed frame did not start the check")
  `CRCFR_ASSERT_NXT(a_last_result_reopens_rx, cmd.out_ld && cmd.out_last, state_r == S_RX,
                    "final result did not return to receive")
  `CRCFR_ASSERT_IMP(a_fill_clear_when_busy, state_r != S_RX, fill_r == '0,
                    "fill count not clear outside receive")

endmodule
`default_nettype wire

@@ design/crc32_checked_frame_receiver.sv @@
// Receive: one byte item per cycle while no frame is being checked or streamed.
// Check: an error result is loaded in S_CHKV, after S_RDV, once the output slot is
// free; for a good frame S_SEQL and S_SEQH follow, then S_STRM loads FRAME_BYTES-4
// results, one per cycle while the slot is free, paced by the store's single read port.
// Reset (rst_n low, synchronous): config to defaults, CRC to all ones, no open frame.
// The frame store is not cleared.
`default_nettype none
module crc32_checked_frame_receiver #(
  parameter int FRAME_BYTES = crcfr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [crcfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] rx_byte
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] data_byte, [13:8] byte_position, [29:14] sequence_res, [30] sequence_gap
  output logic [31:0]                           out_tdata,
  output logic                                  out_tlast,
  output logic [1:0]                            out_tuser   // [1:0] status
);

  crcfr_pkg::dp_cmd_t              cmd;
  crcfr_pkg::dp_stat_t             stat;
  crcfr_pkg::status_t              status;
  logic [7:0]                      data_byte;
  logic [crcfr_pkg::ADDR_W-1:0]    byte_position;
  logic [15:0]                     sequence_res;
  logic                            sequence_gap;

  crcfr_ctrl #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  crcfr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .rx_byte      (in_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .data_byte    (data_byte),
    .byte_position(byte_position),
    .last         (out_tlast),
    .status       (status),
    .sequence_res (sequence_res),
    .sequence_gap (sequence_gap)
  );

  assign out_tdata = {1'b0, sequence_gap, sequence_res, byte_position, data_byte};
  assign out_tuser = status;

endmodule
`default_nettype wire
